// ===== rtl/core/tel_pkg.sv =====
// Package: shared types, character and register codes for the tab expand filter.
`timescale 1ns / 1ps

package tel_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] MODE_PASS       = 3'd0;
    localparam logic [2:0] MODE_OLD        = 3'd1;
    localparam logic [2:0] MODE_COMB       = 3'd2;
    localparam logic [2:0] MODE_COMB_CRLF  = 3'd3;
    localparam logic [2:0] MODE_TABS       = 3'd4;
    localparam logic [2:0] MODE_LF_CRLF    = 3'd5;
    localparam logic [2:0] MODE_DROP_CR    = 3'd6;

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_TAB_WIDTH = 1'b1;

    localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;
    localparam logic [4:0] TAB_WIDTH_MAX   = 5'd16;

    // Output job for one input word: held spaces, optional CR, then the byte.
    typedef struct packed {
        logic [5:0] spaces;
        logic       cr;
        logic [7:0] data;
    } t_job;

    // Column phase modulo the tab width, restoring compare-subtract.
    function automatic logic [3:0] phase_mod(input logic [3:0] p, input logic [4:0] w);
        logic [8:0] rem;
        logic [8:0] sub;
        rem = {5'd0, p};
        for (int k = 3; k >= 0; k--) begin
            sub = {4'd0, w} << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[3:0];
    endfunction

endpackage

// ===== rtl/core/tel_decide.sv =====
// Line state and per-word decision: updates column, held spaces and text flag.
`timescale 1ns / 1ps

module tel_decide #(
    parameter int MAX_PENDING = 62
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic [2:0]        i_mode,
    input  logic [4:0]        i_tab_width,
    output tel_pkg::t_job     o_job,
    output logic              o_load
);

    logic [3:0] r_phase, n_phase;
    logic [5:0] r_pend,  n_pend;
    logic       r_seen,  n_seen;

    logic [4:0] w;
    logic [3:0] ph;
    logic [4:0] ph_inc;
    logic [3:0] ph_next;
    logic [4:0] gap;
    logic [4:0] hold_n;
    logic [6:0] sum;
    logic [5:0] sat;
    logic       expand;
    logic       is_tab;
    logic       stop_tab;
    logic       lead_tab;

    always_comb begin
        if (i_tab_width == 5'd0) begin
            w = 5'd1;
        end else if (i_tab_width > tel_pkg::TAB_WIDTH_MAX) begin
            w = tel_pkg::TAB_WIDTH_MAX;
        end else begin
            w = i_tab_width;
        end
    end

    assign ph      = tel_pkg::phase_mod(r_phase, w);
    assign ph_inc  = {1'b0, ph} + 5'd1;
    assign ph_next = (ph_inc == w) ? 4'd0 : ph_inc[3:0];
    assign gap     = w - {1'b0, ph};

    assign expand = (i_mode == tel_pkg::MODE_OLD) || (i_mode == tel_pkg::MODE_COMB) ||
                    (i_mode == tel_pkg::MODE_COMB_CRLF) || (i_mode == tel_pkg::MODE_TABS);
    assign is_tab = (i_byte == tel_pkg::CH_TAB);
    assign stop_tab = is_tab && ((i_mode == tel_pkg::MODE_TABS) ||
                      (((i_mode == tel_pkg::MODE_COMB) ||
                        (i_mode == tel_pkg::MODE_COMB_CRLF)) && r_seen));
    assign lead_tab = is_tab && (i_mode != tel_pkg::MODE_TABS) && !r_seen;

    assign hold_n = stop_tab ? gap : (lead_tab ? w : 5'd1);
    assign sum    = {1'b0, r_pend} + {2'b00, hold_n};
    assign sat    = (sum > 7'(MAX_PENDING)) ? 6'(MAX_PENDING) : sum[5:0];

    always_comb begin
        n_phase      = ph;
        n_pend       = r_pend;
        n_seen       = r_seen;
        o_job.spaces = 6'd0;
        o_job.cr     = 1'b0;
        o_job.data   = i_byte;
        o_load       = 1'b1;
        if (expand) begin
            priority if (stop_tab) begin
                n_pend  = sat;
                n_phase = 4'd0;
                o_load  = 1'b0;
            end else if (lead_tab) begin
                n_pend  = sat;
                o_load  = 1'b0;
            end else if (i_byte == tel_pkg::CH_SPACE) begin
                n_pend  = sat;
                n_phase = ph_next;
                o_load  = 1'b0;
            end else if (i_byte == tel_pkg::CH_LF) begin
                if ((i_mode == tel_pkg::MODE_OLD) || (i_mode == tel_pkg::MODE_COMB_CRLF)) begin
                    o_job.spaces = r_pend;
                end
                o_job.cr = (i_mode == tel_pkg::MODE_COMB_CRLF);
                n_pend   = 6'd0;
                n_phase  = 4'd0;
                if (i_mode != tel_pkg::MODE_TABS) begin
                    n_seen = 1'b0;
                end
            end else begin
                if (i_mode != tel_pkg::MODE_TABS) begin
                    n_seen = 1'b1;
                end
                o_job.spaces = r_pend;
                n_pend       = 6'd0;
                n_phase      = ph_next;
            end
        end else if (i_mode == tel_pkg::MODE_LF_CRLF) begin
            o_job.cr = (i_byte == tel_pkg::CH_LF);
        end else if (i_mode == tel_pkg::MODE_DROP_CR) begin
            o_load = (i_byte != tel_pkg::CH_CR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 4'd0;
            r_pend  <= 6'd0;
            r_seen  <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_seen  <= n_seen;
        end
    end

endmodule

// ===== rtl/core/tel_emit.sv =====
// Job and output registers play out spaces, CR, byte; one word a cycle unless stalled.
`timescale 1ns / 1ps

module tel_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tel_pkg::t_job     i_job,
    output logic              o_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_last
);

    logic          r_job_valid;
    tel_pkg::t_job r_job;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          out_free;
    logic          mv;
    logic [7:0]    elem;
    logic          elem_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign mv       = r_job_valid && out_free;

    always_comb begin
        if (r_job.spaces != 6'd0) begin
            elem      = tel_pkg::CH_SPACE;
            elem_last = 1'b0;
        end else if (r_job.cr) begin
            elem      = tel_pkg::CH_CR;
            elem_last = 1'b0;
        end else begin
            elem      = r_job.data;
            elem_last = 1'b1;
        end
    end

    assign o_ready = !r_job_valid || (mv && elem_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (i_load) begin
            r_job_valid <= 1'b1;
        end else if (mv && elem_last) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end else if (mv) begin
            if (r_job.spaces != 6'd0) begin
                r_job.spaces <= r_job.spaces - 6'd1;
            end else begin
                r_job.cr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv) begin
            r_out_byte <= elem;
            r_out_last <= elem_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/core/tab_expand_line_end_filter_top.sv =====
// Top level of the tab expand / line end filter: config registers, decision and output.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_in_byte        | word in
//  out      | o_out_valid, i_out_ready, o_out_byte, o_last | word out
//  cfg      | i_cfg_we, i_cfg_index, i_cfg_data        | write only
//
// A word that yields one byte goes through the job register, then the output
// register; words follow back to back while the output is not stalled.
// A word that yields N bytes (held spaces, CR, byte) holds the input until the
// job register has played them out, one byte a cycle unless the output stalls.
// Words that yield nothing (held blanks, dropped CR) give no output. Reset is
// synchronous, active low; it resets mode and tab width, the line state and both
// valid flags. Output stalls back up through the output register to o_in_ready.
`timescale 1ns / 1ps

module tab_expand_line_end_filter_top #(
    parameter int MAX_PENDING = 62
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    logic [2:0]    r_mode;
    logic [4:0]    r_tab_width;
    logic          fire;
    logic          load;
    tel_pkg::t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= tel_pkg::MODE_PASS;
            r_tab_width <= tel_pkg::TAB_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tel_pkg::REG_MODE:      r_mode      <= i_cfg_data[2:0];
                tel_pkg::REG_TAB_WIDTH: r_tab_width <= i_cfg_data;
                default:                r_mode      <= r_mode;
            endcase
        end
    end

    assign fire = i_in_valid && o_in_ready;

    tel_decide #(
        .MAX_PENDING (MAX_PENDING)
    ) u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (i_in_byte),
        .i_mode      (r_mode),
        .i_tab_width (r_tab_width),
        .o_job       (job),
        .o_load      (load)
    );

    tel_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire && load),
        .i_job       (job),
        .o_ready     (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // only inserted spaces and CR are ever non-final
    a_nonlast_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |->
            (o_out_byte == tel_pkg::CH_SPACE || o_out_byte == tel_pkg::CH_CR))
        else $error("non-final word is not a space or CR");

    // inserted CR is directly followed by the final LF
    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last && o_out_byte == tel_pkg::CH_CR) |=>
            (o_out_valid && o_last && o_out_byte == tel_pkg::CH_LF))
        else $error("inserted CR not followed by final LF");

    // a job plays out without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=> o_out_valid)
        else $error("gap inside a job");

endmodule
